// ===== rtl/core/heap_sort_ascending_core_defines.svh =====
// assertion macros shared by the sort core
`ifndef HEAP_SORT_ASCENDING_CORE_DEFINES_SVH
`define HEAP_SORT_ASCENDING_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define HSA_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("heap sort core check failed");
`define HSA_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("heap sort core forbidden condition");
`else
`define HSA_ASSERT(name, clk, rst_n, prop)
`define HSA_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ===== rtl/core/hsa_pkg.sv =====
package hsa_pkg;

	localparam int DEPTH = 64;
	localparam int VAL_W = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	// child index 2p+2 can reach 2*DEPTH
	localparam int CHD_W = IDX_W + 2;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [VAL_W-1:0] data;
	} mem_wr_t;

endpackage

// ===== rtl/core/hsa_store.sv =====
module hsa_store (
	input  logic                               clk,
	input  hsa_pkg::mem_wr_t                   wr,
	input  logic [hsa_pkg::IDX_W-1:0]          rd_addr_a,
	input  logic [hsa_pkg::IDX_W-1:0]          rd_addr_b,
	output logic [hsa_pkg::VAL_W-1:0]          rd_data_a,
	output logic [hsa_pkg::VAL_W-1:0]          rd_data_b
);
	import hsa_pkg::*;

	logic [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

// ===== rtl/core/heap_sort_ascending_core.sv =====
// Heapsort of signed 32-bit values held in a 64-entry memory with one write
// and two registered read ports. Values are taken one per cycle while the
// core is idle; the value flagged tlast closes the set and the core stops
// taking input until every result is delivered. Values beyond 64 are dropped
// and tuser is raised on all results of that set. Sorting runs n/2 sifts to
// build the heap and n-1 to extract, each sift walking down the heap in a
// read/compare/write loop on the memory; each sorted result is then read,
// registered and held on the output until it is taken. Results come out in
// ascending order with tlast on the largest.
`include "heap_sort_ascending_core_defines.svh"

module heap_sort_ascending_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [hsa_pkg::VAL_W-1:0] s_tdata,   // [31:0] value
	input  logic                      s_tlast,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [hsa_pkg::VAL_W-1:0] m_tdata,   // [31:0] sorted_value
	output logic                      m_tlast,
	output logic                      m_tuser    // [0] overflow
);
	import hsa_pkg::*;

	typedef enum logic [3:0] {
		IDLE, BLD_RD, BLD_WR, SFT_RD, SFT_CMP, EXT_RD, EXT_WR, OUT_RD, OUT_LD, OUT_WAIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             drop_q;
	logic             building_q;
	logic [IDX_W-1:0] bi_q;
	logic [IDX_W-1:0] end_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] p_q;
	logic [CNT_W-1:0] hsz_q;
	logic [VAL_W-1:0] pv_q;
	logic             m_tvalid_q;
	logic [VAL_W-1:0] m_tdata_q;
	logic             m_tlast_q;
	logic             m_tuser_q;

	mem_wr_t          wr;
	logic [IDX_W-1:0] rd_addr_a;
	logic [IDX_W-1:0] rd_addr_b;
	logic [VAL_W-1:0] rd_data_a;
	logic [VAL_W-1:0] rd_data_b;

	logic             has_room;
	logic [CNT_W-1:0] cnt_nx;
	logic [CHD_W-1:0] c_w;
	logic [CHD_W-1:0] c1_w;
	logic             has_c;
	logic             pick_b;
	logic [VAL_W-1:0] big;
	logic [IDX_W-1:0] big_idx;
	logic             go_down;

	hsa_store u_store (
		.clk       (clk),
		.wr        (wr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	assign has_room = (count_q < CNT_W'(DEPTH));
	assign cnt_nx   = has_room ? count_q + CNT_W'(1) : count_q;

	// sift step: hole holds pv_q, larger child moves up if it beats it
	assign c_w     = {1'b0, p_q, 1'b1};
	assign c1_w    = c_w + CHD_W'(1);
	assign has_c   = (c_w < CHD_W'(hsz_q));
	assign pick_b  = (c1_w < CHD_W'(hsz_q)) && ($signed(rd_data_b) > $signed(rd_data_a));
	assign big     = pick_b ? rd_data_b : rd_data_a;
	assign big_idx = pick_b ? c1_w[IDX_W-1:0] : c_w[IDX_W-1:0];
	assign go_down = has_c && ($signed(big) > $signed(pv_q));

	always_comb begin
		rd_addr_a = '0;
		rd_addr_b = '0;
		wr        = '0;
		unique case (state_q)
			IDLE: begin
				if (s_tvalid && has_room) begin
					wr.en   = 1'b1;
					wr.addr = count_q[IDX_W-1:0];
					wr.data = s_tdata;
				end
			end
			BLD_RD: rd_addr_a = bi_q;
			SFT_RD: begin
				rd_addr_a = c_w[IDX_W-1:0];
				rd_addr_b = c1_w[IDX_W-1:0];
			end
			SFT_CMP: begin
				wr.en   = 1'b1;
				wr.addr = p_q;
				wr.data = go_down ? big : pv_q;
			end
			EXT_RD: begin
				rd_addr_a = '0;
				rd_addr_b = end_q;
			end
			EXT_WR: begin
				// old root goes to the end of the shrinking heap
				wr.en   = 1'b1;
				wr.addr = end_q;
				wr.data = rd_data_a;
			end
			OUT_RD: rd_addr_a = k_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			count_q    <= '0;
			drop_q     <= 1'b0;
			building_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
			m_tuser_q  <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						count_q <= cnt_nx;
						if (!has_room) begin
							drop_q <= 1'b1;
						end
						if (s_tlast) begin
							k_q <= '0;
							if (cnt_nx >= CNT_W'(2)) begin
								building_q <= 1'b1;
								hsz_q      <= cnt_nx;
								bi_q       <= IDX_W'((cnt_nx >> 1) - CNT_W'(1));
								state_q    <= BLD_RD;
							end else begin
								state_q <= OUT_RD;
							end
						end
					end
				end
				BLD_RD: state_q <= BLD_WR;
				BLD_WR: begin
					pv_q    <= rd_data_a;
					p_q     <= bi_q;
					state_q <= SFT_RD;
				end
				SFT_RD: state_q <= SFT_CMP;
				SFT_CMP: begin
					if (go_down) begin
						p_q     <= big_idx;
						state_q <= SFT_RD;
					end else if (building_q) begin
						if (bi_q == '0) begin
							building_q <= 1'b0;
							end_q      <= IDX_W'(count_q - CNT_W'(1));
							state_q    <= EXT_RD;
						end else begin
							bi_q    <= bi_q - IDX_W'(1);
							state_q <= BLD_RD;
						end
					end else if (end_q == IDX_W'(1)) begin
						k_q     <= '0;
						state_q <= OUT_RD;
					end else begin
						end_q   <= end_q - IDX_W'(1);
						state_q <= EXT_RD;
					end
				end
				EXT_RD: state_q <= EXT_WR;
				EXT_WR: begin
					pv_q    <= rd_data_b;
					p_q     <= '0;
					hsz_q   <= CNT_W'(end_q);
					state_q <= SFT_RD;
				end
				OUT_RD: state_q <= OUT_LD;
				OUT_LD: begin
					m_tvalid_q <= 1'b1;
					m_tdata_q  <= rd_data_a;
					m_tlast_q  <= (CNT_W'(k_q) + CNT_W'(1) == count_q);
					m_tuser_q  <= drop_q;
					state_q    <= OUT_WAIT;
				end
				OUT_WAIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (m_tlast_q) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							state_q <= IDLE;
						end else begin
							k_q     <= k_q + IDX_W'(1);
							state_q <= OUT_RD;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	`HSA_ASSERT(a_no_input_while_result, clk, arst_n, m_tvalid |-> !s_tready)
	`HSA_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(DEPTH))
	`HSA_ASSERT(a_sift_in_heap, clk, arst_n, (state_q == SFT_CMP) |-> (CNT_W'(p_q) < hsz_q))
	`HSA_ASSERT(a_run_clears, clk, arst_n, (m_tvalid && m_tready && m_tlast) |=> (count_q == '0))

endmodule
